// File: sv/tcw_pkg.sv
// shared types and constants for the text console writer
// no dependencies; imported by tcw_ctrl, tcw_dpath and text_console_writer_unit
package tcw_pkg;

   // default screen geometry
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // character codes
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   // reset values
   localparam logic [7:0]  ATTR_RESET = 8'h07;
   localparam logic [15:0] CELL_RESET = 16'h0720;

   // command codes
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // input item
   typedef struct packed {
      logic        cmd;
      logic [7:0]  char_code;
      logic [10:0] cell_address;
   } req_type;

   // result item
   typedef struct packed {
      logic [10:0] cursor_position;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
      logic [15:0] cell_value;
      logic        scrolled;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic clear_wr;
      logic scroll_rd;
      logic scroll_wr;
      logic blank_wr;
      logic idx_inc;
      logic idx_zero;
      logic load_out;
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic put_scroll;
      logic idx_last;
      logic copy_last;
      logic out_free;
   } sts_type;

endpackage

// File: sv/text_console_writer_unit.sv
// text console writer: put cursor on a cell store with scrolling, cell read-back
// a taken item passes through the done state, where its result waits for a free output register;
// a new item is taken only once that result is loaded; a put that scrolls first copies each cell
// up a row (a read/write pair per cell on the single-port-pair store), then blanks the bottom row
// reset: synchronous; a clearing pass fills every cell of the store with
// 0x0720 while req_stall is high; cursor 0, attribute 0x07
module text_console_writer_unit #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcw_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);
   import tcw_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // sequencing
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // store, cursor and result register
   tcw_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sv/tcw_ctrl.sv
// controller state machine for the text console writer
// depends on tcw_pkg; drives tcw_dpath through ctl_type commands
module tcw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::sts_type sts,
   output tcw_pkg::ctl_type ctl
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_BLANK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // input side is open only when idle
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear_wr = 1'b1;
            if (sts.idx_last) begin
               ctl.idx_zero = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ctl.idx_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = sts.put_scroll ? ST_SCROLL_RD : ST_DONE;
            end
         end
         ST_SCROLL_RD: begin
            ctl.scroll_rd = 1'b1;
            state_in      = ST_SCROLL_WR;
         end
         ST_SCROLL_WR: begin
            ctl.scroll_wr = 1'b1;
            ctl.idx_inc   = 1'b1;
            state_in      = sts.copy_last ? ST_BLANK : ST_SCROLL_RD;
         end
         ST_BLANK: begin
            ctl.blank_wr = 1'b1;
            if (sts.idx_last) begin
               ctl.idx_zero = 1'b1;
               state_in     = ST_DONE;
            end else begin
               ctl.idx_inc = 1'b1;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               ctl.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // the clearing pass ends only after the last cell
   a_clear_exit: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == ST_CLEAR) && state_ff != ST_CLEAR) |-> $past(sts.idx_last))
      else $error("clearing pass left early");

   // the blanking pass ends only after the last cell
   a_blank_exit: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == ST_BLANK) && state_ff != ST_BLANK) |-> $past(sts.idx_last))
      else $error("blank row pass left early");

   // a result is loaded only into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |-> sts.out_free)
      else $error("result loaded over a waiting one");

endmodule

// File: sv/tcw_dpath.sv
// datapath for the text console writer: cell store, cursor, scroll counter, output register
// depends on tcw_pkg; commanded by tcw_ctrl
module tcw_dpath #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  tcw_pkg::req_type req_payload,
   input  tcw_pkg::ctl_type ctl,
   output tcw_pkg::sts_type sts,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output tcw_pkg::rsp_type rsp_payload
);
   import tcw_pkg::*;

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);

   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] IDX_LAST  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

   // cell store
   logic [15:0] mem [CELLS];
   logic [15:0] rd_data_ff;

   // cursor and control registers
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] idx_ff;
   logic [7:0]        attr_ff;
   logic              cmd_ff;
   logic              in_range_ff;
   logic              scroll_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // decode and memory port signals
   logic              is_put;
   logic              is_nl;
   logic              is_bs;
   logic              in_range;
   logic              put_scroll;
   logic [ADDR_W-1:0] row_start;
   logic [ADDR_W-1:0] put_wa;
   logic [7:0]        put_char;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [15:0]       mem_wd;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_ra;

   assign is_put    = (req_payload.cmd == CMD_PUT);
   assign is_nl     = (req_payload.char_code == CH_NEWLINE);
   assign is_bs     = (req_payload.char_code == CH_BACKSPACE);
   assign in_range  = (32'(req_payload.cell_address) < 32'(CELLS));
   assign row_start = pos_ff - ADDR_W'(col_ff);
   assign put_char  = is_bs ? CH_SPACE : req_payload.char_code;

   // cursor update for a put
   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      pos_in     = pos_ff;
      put_scroll = 1'b0;
      put_wa     = pos_ff;
      if (is_put) begin
         if (is_nl) begin
            col_in = '0;
            if (row_ff == ROW_LAST) begin
               put_scroll = 1'b1;
               pos_in     = row_start;
            end else begin
               row_in = row_ff + ROW_W'(1);
               pos_in = row_start + ROW_STEP;
            end
         end else if (is_bs) begin
            if (col_ff != '0) begin
               col_in = col_ff - COL_W'(1);
               pos_in = pos_ff - ADDR_W'(1);
               put_wa = pos_ff - ADDR_W'(1);
            end
         end else begin
            pos_in = pos_ff + ADDR_W'(1);
            if (col_ff == COL_LAST) begin
               col_in = '0;
               if (row_ff == ROW_LAST) begin
                  put_scroll = 1'b1;
                  pos_in     = row_start;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   // write port select; a newline moves the cursor only
   always_comb begin
      mem_we = 1'b0;
      mem_wa = idx_ff;
      mem_wd = CELL_RESET;
      if (ctl.clear_wr) begin
         mem_we = 1'b1;
      end else if (ctl.scroll_wr) begin
         mem_we = 1'b1;
         mem_wd = rd_data_ff;
      end else if (ctl.blank_wr) begin
         mem_we = 1'b1;
         mem_wd = {attr_ff, CH_SPACE};
      end else if (ctl.accept && is_put && !is_nl) begin
         mem_we = 1'b1;
         mem_wa = put_wa;
         mem_wd = {attr_ff, put_char};
      end
   end

   // read port select
   always_comb begin
      mem_re = 1'b0;
      mem_ra = idx_ff + ROW_STEP;
      if (ctl.scroll_rd) begin
         mem_re = 1'b1;
      end else if (ctl.accept && !is_put && in_range) begin
         mem_re = 1'b1;
         mem_ra = ADDR_W'(req_payload.cell_address);
      end
   end

   // cell store ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // cursor, attribute, item capture and sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         pos_ff  <= '0;
         idx_ff  <= '0;
         attr_ff <= ATTR_RESET;
      end else begin
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
         if (ctl.accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
            pos_ff <= pos_in;
         end
         if (ctl.idx_zero) begin
            idx_ff <= '0;
         end else if (ctl.idx_inc) begin
            idx_ff <= idx_ff + ADDR_W'(1);
         end
      end
   end

   // per item flags
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff      <= req_payload.cmd;
         in_range_ff <= in_range;
         scroll_ff   <= put_scroll;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_ff.cursor_position <= 11'(pos_ff);
         rsp_ff.cursor_row      <= 5'(row_ff);
         rsp_ff.cursor_column   <= 7'(col_ff);
         rsp_ff.cell_value      <= (cmd_ff == CMD_READ && in_range_ff) ? rd_data_ff : 16'h0000;
         rsp_ff.scrolled        <= scroll_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // status to controller
   assign sts.put_scroll = put_scroll;
   assign sts.idx_last   = (idx_ff == IDX_LAST);
   assign sts.copy_last  = (idx_ff == COPY_LAST);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   // linear cursor tracks row and column
   a_pos_match: assert property (@(posedge clock) disable iff (reset)
      pos_ff == ADDR_W'(32'(row_ff) * COLUMNS + 32'(col_ff)))
      else $error("cursor position out of step with row and column");

   // cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < ROWS) && (32'(col_ff) < COLUMNS))
      else $error("cursor off screen");

   // a read never reports a scroll
   a_read_no_scroll: assert property (@(posedge clock) disable iff (reset)
      (ctl.load_out && cmd_ff == CMD_READ) |-> !scroll_ff)
      else $error("read item flagged as scrolled");

endmodule
